// ===== sv/ucts_pkg.sv =====
// Package for the USB control transfer sequencer.
// Holds the event and action codes, the stage and command types and the
// structs passed between the front, the queue and the back. No dependencies.
`default_nettype none

package ucts_pkg;

   localparam int unsigned MAX_PKT     = 64;
   localparam int unsigned MIN_PKT     = 8;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] OP_BUS_RESET = 3'd0;
   localparam logic [2:0] OP_SETUP     = 3'd1;
   localparam logic [2:0] OP_OUT_RX    = 3'd2;
   localparam logic [2:0] OP_IN_SENT   = 3'd3;
   localparam logic [2:0] OP_START_IN  = 3'd4;
   localparam logic [2:0] OP_START_OUT = 3'd5;
   localparam logic [2:0] OP_STATUS    = 3'd6;

   localparam logic [3:0] ACT_SEND        = 4'd0;
   localparam logic [3:0] ACT_STALL       = 4'd1;
   localparam logic [3:0] ACT_ARM         = 4'd2;
   localparam logic [3:0] ACT_ARM_ZERO    = 4'd3;
   localparam logic [3:0] ACT_SETUP_READY = 4'd4;
   localparam logic [3:0] ACT_STORE       = 4'd5;
   localparam logic [3:0] ACT_OUT_DONE    = 4'd6;
   localparam logic [3:0] ACT_IN_DONE     = 4'd7;
   localparam logic [3:0] ACT_STATUS_DONE = 4'd8;
   localparam logic [3:0] ACT_ERROR       = 4'd9;

   typedef enum logic [2:0] {
      CMD_BUS_RESET,
      CMD_SETUP,
      CMD_OUT_RX,
      CMD_IN_SENT,
      CMD_START_IN,
      CMD_START_OUT,
      CMD_STATUS,
      CMD_BAD
   } cmd_type;

   typedef enum logic [5:0] {
      ST_SETUP        = 6'b000001,
      ST_DATA_IN      = 6'b000010,
      ST_DATA_IN_LAST = 6'b000100,
      ST_DATA_OUT     = 6'b001000,
      ST_STATUS_IN    = 6'b010000,
      ST_STATUS_OUT   = 6'b100000
   } stage_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [6:0]  rx_bytes;
      logic [15:0] block_len;
      logic        success;
      logic        len_short;
      logic [15:0] len_rem;
      logic        rx_short;
   } qent_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [6:0]  pkt_len;
      logic [15:0] offset;
      logic [15:0] byte_count;
      logic        status_dir_in;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/ucts_if.sv =====
// Request and response channel interfaces of the USB control transfer sequencer.
// Valid/ready handshake with the payload fields; no dependencies.
`default_nettype none

interface ucts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  op;
   logic [6:0]  rx_bytes;
   logic [15:0] block_len;
   logic        success;

   modport source(output valid, op, rx_bytes, block_len, success, input ready);
   modport sink(input valid, op, rx_bytes, block_len, success, output ready);
endinterface

interface ucts_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [6:0]  pkt_len;
   logic [15:0] offset;
   logic [15:0] byte_count;
   logic        status_dir_in;
   logic        last;

   modport source(output valid, action, pkt_len, offset, byte_count, status_dir_in, last,
                  input ready);
   modport sink(input valid, action, pkt_len, offset, byte_count, status_dir_in, last,
                output ready);
endinterface

`default_nettype wire

// ===== sv/ucts_front.sv =====
// Front end: accepts requests and classifies them into queue entries.
// Depends on ucts_pkg and ucts_req_if.
`default_nettype none

module ucts_front
   import ucts_pkg::*;
(
   ucts_req_if.sink    req,
   input  wire logic [6:0] max_pkt,
   input  wire logic       q_full,
   output logic            q_push,
   output qent_type        q_data
);

   cmd_type cmd;

   always_comb begin
      case (req.op)
         OP_BUS_RESET: begin
            cmd = CMD_BUS_RESET;
         end
         OP_SETUP: begin
            cmd = CMD_SETUP;
         end
         OP_OUT_RX: begin
            cmd = CMD_OUT_RX;
         end
         OP_IN_SENT: begin
            cmd = CMD_IN_SENT;
         end
         OP_START_IN: begin
            cmd = CMD_START_IN;
         end
         OP_START_OUT: begin
            cmd = CMD_START_OUT;
         end
         OP_STATUS: begin
            cmd = CMD_STATUS;
         end
         default: begin
            cmd = CMD_BAD;
         end
      endcase
   end

   assign req.ready = ~q_full;
   assign q_push    = req.valid & ~q_full;

   always_comb begin
      q_data.cmd       = cmd;
      q_data.rx_bytes  = req.rx_bytes;
      q_data.block_len = req.block_len;
      q_data.success   = req.success;
      q_data.len_short = req.block_len < {9'd0, max_pkt};
      q_data.len_rem   = req.block_len - {9'd0, max_pkt};
      q_data.rx_short  = req.rx_bytes < max_pkt;
   end

endmodule

`default_nettype wire

// ===== sv/ucts_queue.sv =====
// Short FIFO of classified requests between the front and the back.
// Depends on ucts_pkg.
`default_nettype none

module ucts_queue
   import ucts_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire qent_type din,
   output logic          full,
   input  wire logic     pop,
   output logic          valid,
   output qent_type      dout
);

   qent_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                do_pop;

   assign full   = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign valid  = cnt_ff != '0;
   assign dout   = mem_ff[rd_ptr_ff];
   assign do_pop = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

endmodule

`default_nettype wire

// ===== sv/ucts_back.sv =====
// Back end: runs the control stage machine on queued requests and holds up to
// two pending responses. Depends on ucts_pkg and ucts_rsp_if.
`default_nettype none

module ucts_back
   import ucts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [6:0] max_pkt,
   input  wire logic       q_valid,
   input  wire qent_type   q_data,
   output logic            q_pop,
   ucts_rsp_if.source      rsp
);

   stage_type   stage_ff, stage_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [15:0] buf_pos_ff, buf_pos_in;
   result_type  slot0_ff, slot0_in;
   result_type  slot1_ff, slot1_in;
   logic [1:0]  cnt_ff, cnt_in;

   result_type  r0;
   result_type  r1;
   logic        two;
   logic        rsp_take;
   logic        rx_ge;
   logic [6:0]  use_len;
   logic        out_done;
   logic [6:0]  pkt;

   assign rsp_take = rsp.valid & rsp.ready;
   assign q_pop    = q_valid & ((cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & rsp_take));

   assign rx_ge    = {9'd0, q_data.rx_bytes} >= bytes_left_ff;
   assign use_len  = rx_ge ? bytes_left_ff[6:0] : q_data.rx_bytes;
   assign out_done = q_data.rx_short | rx_ge;

   always_comb begin
      r0            = '0;
      r1            = '0;
      two           = 1'b0;
      pkt           = '0;
      stage_in      = stage_ff;
      bytes_left_in = bytes_left_ff;
      buf_pos_in    = buf_pos_ff;
      case (q_data.cmd)
         CMD_BUS_RESET: begin
            stage_in      = ST_SETUP;
            bytes_left_in = '0;
            buf_pos_in    = '0;
            r0.action     = ACT_ARM;
            r0.pkt_len    = max_pkt;
         end
         CMD_SETUP: begin
            stage_in      = ST_SETUP;
            bytes_left_in = '0;
            buf_pos_in    = '0;
            r0.action     = ACT_SETUP_READY;
         end
         CMD_OUT_RX: begin
            if (stage_ff == ST_STATUS_IN) begin
               stage_in         = ST_SETUP;
               r0.action        = ACT_ARM;
               r0.pkt_len       = max_pkt;
               r1.action        = ACT_STATUS_DONE;
               r1.status_dir_in = 1'b1;
               two              = 1'b1;
            end else if (stage_ff == ST_DATA_OUT) begin
               bytes_left_in = bytes_left_ff - {9'd0, use_len};
               buf_pos_in    = buf_pos_ff + {9'd0, use_len};
               if (use_len != '0) begin
                  r0.action  = ACT_STORE;
                  r0.pkt_len = use_len;
                  r0.offset  = buf_pos_ff;
                  two        = 1'b1;
                  if (out_done) begin
                     r1.action     = ACT_OUT_DONE;
                     r1.byte_count = buf_pos_in;
                  end else begin
                     r1.action  = ACT_ARM;
                     r1.pkt_len = max_pkt;
                  end
               end else if (out_done) begin
                  r0.action     = ACT_OUT_DONE;
                  r0.byte_count = buf_pos_ff;
               end else begin
                  r0.action  = ACT_ARM;
                  r0.pkt_len = max_pkt;
               end
            end else begin
               r0.action = ACT_ERROR;
            end
         end
         CMD_IN_SENT: begin
            if (stage_ff == ST_DATA_IN) begin
               if (bytes_left_ff == '0) begin
                  pkt      = '0;
                  stage_in = ST_DATA_IN_LAST;
               end else if (bytes_left_ff < {9'd0, max_pkt}) begin
                  pkt           = bytes_left_ff[6:0];
                  bytes_left_in = '0;
                  stage_in      = ST_DATA_IN_LAST;
               end else begin
                  pkt           = max_pkt;
                  bytes_left_in = bytes_left_ff - {9'd0, max_pkt};
               end
               buf_pos_in = buf_pos_ff + {9'd0, pkt};
               r0.action  = ACT_SEND;
               r0.pkt_len = pkt;
               r0.offset  = buf_pos_ff;
            end else if (stage_ff == ST_DATA_IN_LAST) begin
               stage_in  = ST_STATUS_IN;
               r0.action = ACT_ARM_ZERO;
               r1.action = ACT_IN_DONE;
               two       = 1'b1;
            end else if (stage_ff == ST_STATUS_OUT) begin
               stage_in   = ST_SETUP;
               r0.action  = ACT_ARM;
               r0.pkt_len = max_pkt;
               r1.action  = ACT_STATUS_DONE;
               two        = 1'b1;
            end else begin
               r0.action = ACT_ERROR;
            end
         end
         CMD_START_IN: begin
            if (q_data.len_short) begin
               pkt           = q_data.block_len[6:0];
               stage_in      = ST_DATA_IN_LAST;
               bytes_left_in = '0;
            end else begin
               pkt           = max_pkt;
               stage_in      = ST_DATA_IN;
               bytes_left_in = q_data.len_rem;
            end
            buf_pos_in = {9'd0, pkt};
            r0.action  = ACT_SEND;
            r0.pkt_len = pkt;
         end
         CMD_START_OUT: begin
            stage_in      = ST_DATA_OUT;
            bytes_left_in = q_data.block_len;
            buf_pos_in    = '0;
            r0.action     = ACT_ARM;
            r0.pkt_len    = max_pkt;
         end
         CMD_STATUS: begin
            if (q_data.success) begin
               stage_in  = ST_STATUS_OUT;
               r0.action = ACT_SEND;
            end else begin
               stage_in   = ST_SETUP;
               r0.action  = ACT_STALL;
               r1.action  = ACT_ARM;
               r1.pkt_len = max_pkt;
               two        = 1'b1;
            end
         end
         default: begin
            r0.action = ACT_ERROR;
         end
      endcase
      if (two) begin
         r1.last = 1'b1;
      end else begin
         r0.last = 1'b1;
      end
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      cnt_in   = cnt_ff;
      if (q_pop) begin
         slot0_in = r0;
         slot1_in = r1;
         cnt_in   = two ? 2'd2 : 2'd1;
      end else if (rsp_take) begin
         slot0_in = slot1_ff;
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff      <= ST_SETUP;
         bytes_left_ff <= '0;
         buf_pos_ff    <= '0;
         cnt_ff        <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (q_pop) begin
            stage_ff      <= stage_in;
            bytes_left_ff <= bytes_left_in;
            buf_pos_ff    <= buf_pos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp.valid         = cnt_ff != 2'd0;
   assign rsp.action        = slot0_ff.action;
   assign rsp.pkt_len       = slot0_ff.pkt_len;
   assign rsp.offset        = slot0_ff.offset;
   assign rsp.byte_count    = slot0_ff.byte_count;
   assign rsp.status_dir_in = slot0_ff.status_dir_in;
   assign rsp.last          = slot0_ff.last;

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("Response buffer count out of range.");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> rsp.valid)
      else $error("A taken request did not present a response.");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> slot0_ff.last)
      else $error("The only pending response is not marked last.");

   a_pair_first: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> (!slot0_ff.last && slot1_ff.last))
      else $error("A response pair is marked wrongly.");
`endif

endmodule

`default_nettype wire

// ===== sv/usb_control_transfer_sequencer.sv =====
// Top level of the USB control transfer sequencer: front, request queue, back
// and the max packet register. Depends on ucts_pkg, ucts_if, ucts_front,
// ucts_queue and ucts_back.
//
// A request is taken into a two-entry queue at the edge it is accepted, and
// the back end pops it once it is stored and the response buffer has room;
// its first response is presented in the cycle after the pop. The back end
// delivers one response per cycle while rsp.ready is high, and takes a new
// request when its buffer is empty or its last pending response is taken;
// the response buffer of the back end sets this rate. The packet size written
// through csr_wdata is clamped to 8..64 when stored, and must only be written while no request is pending.
`default_nettype none

module usb_control_transfer_sequencer
   import ucts_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   ucts_req_if.sink        req,
   ucts_rsp_if.source      rsp,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);

   logic [6:0] max_pkt_ff, max_pkt_in;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_valid;
   qent_type   q_din;
   qent_type   q_dout;

   always_comb begin
      max_pkt_in = max_pkt_ff;
      if (csr_we) begin
         if (csr_wdata > 7'(MAX_PKT)) begin
            max_pkt_in = 7'(MAX_PKT);
         end else if (csr_wdata < 7'(MIN_PKT)) begin
            max_pkt_in = 7'(MIN_PKT);
         end else begin
            max_pkt_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_pkt_ff <= 7'(MAX_PKT);
      end else begin
         max_pkt_ff <= max_pkt_in;
      end
   end

   ucts_front u_front (
      .req     (req),
      .max_pkt (max_pkt_ff),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_data  (q_din)
   );

   ucts_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (q_din),
      .full  (q_full),
      .pop   (q_pop),
      .valid (q_valid),
      .dout  (q_dout)
   );

   ucts_back u_back (
      .clock   (clock),
      .reset   (reset),
      .max_pkt (max_pkt_ff),
      .q_valid (q_valid),
      .q_data  (q_dout),
      .q_pop   (q_pop),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for the USB control transfer sequencer: random control transfers
// with bursty requests and response stalls, checked against an in-bench transfer model.
// Depends on ucts_pkg, the ucts_req_if/ucts_rsp_if interfaces and the sequencer RTL.
`timescale 1ns / 100ps

module tb_top;
   import ucts_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_REQUESTS = 205;
   localparam logic [2:0] OP_UNUSED = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [6:0]  rx_bytes;
      logic [15:0] block_len;
      logic        success;
   } ctrl_event_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_we = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   ucts_req_if req_bus();
   ucts_rsp_if rsp_bus();

   usb_control_transfer_sequencer dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   ctrl_event_type event_queue[$];
   result_type     expected_actions[$];
   ctrl_event_type cur_event;
   int          queued_cnt = 0;
   int          accepted_cnt = 0;
   int          mismatch_cnt = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int unsigned rx_cycle = 0;
   int          stall_left = 0;
   int          idle_cycles = 0;
   logic        hold_off = 1'b0;

   logic [6:0]  pkt_size_reg = 7'd64;
   stage_type   xfer_stage = ST_SETUP;
   logic [15:0] xfer_left = 16'd0;
   logic [15:0] xfer_total = 16'd0;
   logic [15:0] xfer_pos = 16'd0;

   function automatic logic [6:0] eff_size(logic [6:0] v);
      if (v > 7'(MAX_PKT)) return 7'(MAX_PKT);
      if (v < 7'(MIN_PKT)) return 7'(MIN_PKT);
      return v;
   endfunction

   task automatic expect_action(logic [3:0] act, logic [6:0] len, logic [15:0] off,
                                logic [15:0] cnt, logic dir, logic fin);
      result_type r;
      r.action = act;
      r.pkt_len = len;
      r.offset = off;
      r.byte_count = cnt;
      r.status_dir_in = dir;
      r.last = fin;
      expected_actions.push_back(r);
   endtask

   task automatic advance_transfer(ctrl_event_type ev);
      logic [6:0]  mp;
      logic [15:0] use_len;
      logic [15:0] pkt;
      mp = eff_size(pkt_size_reg);
      case (ev.op)
         OP_BUS_RESET, OP_SETUP: begin
            xfer_stage = ST_SETUP;
            xfer_left = 16'd0;
            xfer_total = 16'd0;
            xfer_pos = 16'd0;
            if (ev.op == OP_BUS_RESET) expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b1);
            else expect_action(ACT_SETUP_READY, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
         end
         OP_OUT_RX: begin
            if (xfer_stage == ST_STATUS_IN) begin
               xfer_stage = ST_SETUP;
               expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b0);
               expect_action(ACT_STATUS_DONE, 7'd0, 16'd0, 16'd0, 1'b1, 1'b1);
            end else if (xfer_stage == ST_DATA_OUT) begin
               use_len = ({9'd0, ev.rx_bytes} < xfer_left) ? {9'd0, ev.rx_bytes} : xfer_left;
               if (use_len != 16'd0) begin
                  expect_action(ACT_STORE, use_len[6:0], xfer_pos, 16'd0, 1'b0, 1'b0);
                  xfer_left = xfer_left - use_len;
                  xfer_pos = xfer_pos + use_len;
               end
               if (ev.rx_bytes < mp || xfer_left == 16'd0)
                  expect_action(ACT_OUT_DONE, 7'd0, 16'd0, xfer_total - xfer_left, 1'b0, 1'b1);
               else
                  expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               expect_action(ACT_ERROR, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            end
         end
         OP_IN_SENT: begin
            if (xfer_stage == ST_DATA_IN) begin
               if (xfer_left == 16'd0) begin
                  pkt = 16'd0;
                  xfer_stage = ST_DATA_IN_LAST;
               end else if (xfer_left < {9'd0, mp}) begin
                  pkt = xfer_left;
                  xfer_left = 16'd0;
                  xfer_stage = ST_DATA_IN_LAST;
               end else begin
                  pkt = {9'd0, mp};
                  xfer_left = xfer_left - pkt;
               end
               expect_action(ACT_SEND, pkt[6:0], xfer_pos, 16'd0, 1'b0, 1'b1);
               xfer_pos = xfer_pos + pkt;
            end else if (xfer_stage == ST_DATA_IN_LAST) begin
               xfer_stage = ST_STATUS_IN;
               expect_action(ACT_ARM_ZERO, 7'd0, 16'd0, 16'd0, 1'b0, 1'b0);
               expect_action(ACT_IN_DONE, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            end else if (xfer_stage == ST_STATUS_OUT) begin
               xfer_stage = ST_SETUP;
               expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b0);
               expect_action(ACT_STATUS_DONE, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               expect_action(ACT_ERROR, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            end
         end
         OP_START_IN: begin
            xfer_total = ev.block_len;
            if (ev.block_len < {9'd0, mp}) begin
               xfer_stage = ST_DATA_IN_LAST;
               xfer_left = 16'd0;
               pkt = ev.block_len;
            end else begin
               xfer_stage = ST_DATA_IN;
               xfer_left = ev.block_len - {9'd0, mp};
               pkt = {9'd0, mp};
            end
            xfer_pos = pkt;
            expect_action(ACT_SEND, pkt[6:0], 16'd0, 16'd0, 1'b0, 1'b1);
         end
         OP_START_OUT: begin
            xfer_stage = ST_DATA_OUT;
            xfer_total = ev.block_len;
            xfer_left = ev.block_len;
            xfer_pos = 16'd0;
            expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b1);
         end
         OP_STATUS: begin
            if (ev.success) begin
               xfer_stage = ST_STATUS_OUT;
               expect_action(ACT_SEND, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
            end else begin
               xfer_stage = ST_SETUP;
               expect_action(ACT_STALL, 7'd0, 16'd0, 16'd0, 1'b0, 1'b0);
               expect_action(ACT_ARM, mp, 16'd0, 16'd0, 1'b0, 1'b1);
            end
         end
         default: expect_action(ACT_ERROR, 7'd0, 16'd0, 16'd0, 1'b0, 1'b1);
      endcase
   endtask

   // Fields that the operation does not use carry random values.
   task automatic issue_event(logic [2:0] op, logic [6:0] rx, logic [15:0] len, logic ok);
      ctrl_event_type ev;
      ev.op = op;
      ev.rx_bytes = (op == OP_OUT_RX) ? rx : 7'($urandom_range(0, 64));
      ev.block_len = (op == OP_START_IN || op == OP_START_OUT) ? len : 16'($urandom);
      ev.success = (op == OP_STATUS) ? ok : 1'($urandom);
      event_queue.push_back(ev);
      queued_cnt++;
   endtask

   task automatic random_transfer();
      logic [6:0]  mp;
      logic [15:0] len;
      logic [15:0] remain;
      logic [6:0]  rx;
      logic        ok;
      int          kind;
      int          n_pkts;
      int          cnt;
      mp = eff_size(pkt_size_reg);
      kind = $urandom_range(0, 9);
      case ($urandom_range(0, 15))
         0: len = 16'd0;
         1: len = {9'd0, mp};
         2: len = {8'd0, mp, 1'b0};
         3: len = {9'd0, mp} - 16'd1;
         4: len = {9'd0, mp} + 16'd1;
         5: len = 16'hFFFF;
         default: len = 16'($urandom_range(0, 4 * int'(mp)));
      endcase
      if ($urandom_range(0, 9) == 0) issue_event(OP_BUS_RESET, 7'd0, 16'd0, 1'b0);
      if (kind < 8) issue_event(OP_SETUP, 7'd0, 16'd0, 1'b0);
      case (kind)
         0, 1, 2: begin
            issue_event(OP_START_IN, 7'd0, len, 1'b0);
            n_pkts = (len >= {9'd0, mp}) ? int'((len - {9'd0, mp}) / {9'd0, mp}) + 1 : 0;
            if (n_pkts > 8) begin
               repeat (3) issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
            end else begin
               repeat (n_pkts + 1) issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
               if ($urandom_range(0, 7) == 0) issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
               if ($urandom_range(0, 3) != 0)
                  issue_event(OP_OUT_RX, 7'($urandom_range(0, 64)), 16'd0, 1'b0);
               else
                  issue_event(OP_STATUS, 7'd0, 16'd0, 1'b0);
            end
         end
         3, 4, 5: begin
            issue_event(OP_START_OUT, 7'd0, len, 1'b0);
            remain = len;
            cnt = 0;
            do begin
               if ($urandom_range(0, 7) == 0) rx = 7'($urandom_range(0, 64));
               else rx = (remain >= {9'd0, mp}) ? mp : remain[6:0];
               issue_event(OP_OUT_RX, rx, 16'd0, 1'b0);
               remain = ({9'd0, rx} < remain) ? remain - {9'd0, rx} : 16'd0;
               cnt++;
            end while (remain != 16'd0 && rx >= mp && cnt < 8);
            if ($urandom_range(0, 5) == 0)
               issue_event(OP_OUT_RX, 7'($urandom_range(0, 64)), 16'd0, 1'b0);
            ok = ($urandom_range(0, 3) != 0);
            issue_event(OP_STATUS, 7'd0, 16'd0, ok);
            if (ok) issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
         end
         6, 7: begin
            ok = ($urandom_range(0, 3) != 0);
            issue_event(OP_STATUS, 7'd0, 16'd0, ok);
            if (ok) issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
         end
         default: begin
            repeat ($urandom_range(1, 4))
               issue_event(3'($urandom_range(0, 7)), 7'($urandom_range(0, 64)),
                           16'($urandom), 1'($urandom));
         end
      endcase
   endtask

   task automatic drain();
      do @(posedge clock);
      while (accepted_cnt != queued_cnt || expected_actions.size() != 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_packet_size(logic [6:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      pkt_size_reg = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (req_bus.valid) begin
            advance_transfer(cur_event);
            accepted_cnt++;
         end
         if (gap_left != 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (event_queue.size() != 0) begin
            cur_event = event_queue.pop_front();
            req_bus.op <= cur_event.op;
            req_bus.rx_bytes <= cur_event.rx_bytes;
            req_bus.block_len <= cur_event.block_len;
            req_bus.success <= cur_event.success;
            req_bus.valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 16);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.action = rsp_bus.action;
            got.pkt_len = rsp_bus.pkt_len;
            got.offset = rsp_bus.offset;
            got.byte_count = rsp_bus.byte_count;
            got.status_dir_in = rsp_bus.status_dir_in;
            got.last = rsp_bus.last;
            if (expected_actions.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("Unexpected response: act %0d len %0d off %0d cnt %0d dir %0d last %0d",
                           got.action, got.pkt_len, got.offset, got.byte_count,
                           got.status_dir_in, got.last);
            end else begin
               want = expected_actions.pop_front();
               if (got.action !== want.action || got.pkt_len !== want.pkt_len ||
                   got.offset !== want.offset || got.byte_count !== want.byte_count ||
                   got.status_dir_in !== want.status_dir_in || got.last !== want.last) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("Mismatch: got act %0d len %0d off %0d cnt %0d dir %0d last %0d, %s",
                              got.action, got.pkt_len, got.offset, got.byte_count,
                              got.status_dir_in, got.last,
                              $sformatf("expected act %0d len %0d off %0d cnt %0d dir %0d last %0d",
                                        want.action, want.pkt_len, want.offset,
                                        want.byte_count, want.status_dir_in, want.last));
               end
            end
         end
         rx_cycle <= rx_cycle + 1;
         if (stall_left != 0)
            stall_left <= stall_left - 1;
         else if (rx_cycle[7] && $urandom_range(0, 15) == 0)
            stall_left <= $urandom_range(1, 12);
         rsp_bus.ready <= !hold_off &&
                          (!rx_cycle[7] || (stall_left == 0 && $urandom_range(0, 2) != 0));
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // The response side holds off for a long stretch so that the request side backs up.
   initial begin
      wait (accepted_cnt >= 300);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (300) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      logic [6:0] phase_size[8];
      int         target;
      req_bus.valid = 1'b0;
      req_bus.op = OP_BUS_RESET;
      req_bus.rx_bytes = 7'd0;
      req_bus.block_len = 16'd0;
      req_bus.success = 1'b0;
      rsp_bus.ready = 1'b0;
      phase_size[0] = 7'd8;
      phase_size[1] = 7'd0;
      phase_size[2] = 7'd127;
      phase_size[3] = 7'($urandom_range(9, 63));
      phase_size[4] = 7'd64;
      phase_size[5] = 7'($urandom_range(8, 64));
      phase_size[6] = 7'd16;
      phase_size[7] = 7'($urandom_range(65, 127));
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_packet_size(7'd64);

      issue_event(OP_UNUSED, 7'd0, 16'd0, 1'b0);
      issue_event(OP_OUT_RX, 7'd10, 16'd0, 1'b0);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_BUS_RESET, 7'd0, 16'd0, 1'b0);
      issue_event(OP_SETUP, 7'd0, 16'd0, 1'b0);
      issue_event(OP_START_IN, 7'd0, 16'd0, 1'b0);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_OUT_RX, 7'd0, 16'd0, 1'b0);
      issue_event(OP_SETUP, 7'd0, 16'd0, 1'b0);
      issue_event(OP_START_IN, 7'd0, 16'd64, 1'b0);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_STATUS, 7'd0, 16'd0, 1'b0);
      issue_event(OP_START_OUT, 7'd0, 16'hFFFF, 1'b0);
      issue_event(OP_OUT_RX, 7'd64, 16'd0, 1'b0);
      issue_event(OP_OUT_RX, 7'd5, 16'd0, 1'b0);
      issue_event(OP_START_OUT, 7'd0, 16'd3, 1'b0);
      issue_event(OP_OUT_RX, 7'd64, 16'd0, 1'b0);
      issue_event(OP_OUT_RX, 7'd0, 16'd0, 1'b0);
      issue_event(OP_STATUS, 7'd0, 16'd0, 1'b1);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_START_IN, 7'd0, 16'hFFFF, 1'b0);
      issue_event(OP_IN_SENT, 7'd0, 16'd0, 1'b0);
      issue_event(OP_OUT_RX, 7'd64, 16'd0, 1'b0);
      issue_event(OP_START_IN, 7'd0, 16'd63, 1'b0);
      issue_event(OP_SETUP, 7'd0, 16'd0, 1'b0);

      for (int p = 0; p < 8; p++) begin
         write_packet_size(phase_size[p]);
         target = queued_cnt + PHASE_REQUESTS;
         while (queued_cnt < target) random_transfer();
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatch_cnt == 0 && expected_actions.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
